// ===== rtl/gfba_pkg.sv =====
`default_nettype none

package gfba_pkg;

	// Pool and group geometry.
	localparam int NUM_BLOCKS = 127;
	localparam int GROUP_SIZE = 16;

	// Field widths.
	localparam int BLK_W = 7;
	localparam int CNT_W = 5;
	localparam int GRP_W = $clog2(GROUP_SIZE);
	localparam int SPILL_AW = BLK_W + GRP_W;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_EMPTY = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP = 4'b0010,
		S_SPILL = 4'b0100,
		S_REFILL = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/grouped_free_block_allocator.sv =====
`default_nettype none

// Channel   Transfer when            Signals
// -------   ----------------------   -------------------------------------------
// command   start && !busy           opcode, block_number
// result    done (one cycle only)    status, allocated_block, group_count
//
// A free that fits in the group, a rejected free and an allocate from an empty
// pool give their result in the cycle after the command transfer; a plain allocate
// answers from S_POP after one group RAM read. A spill moves the group one word a cycle
// and answers once the last word is written; a refill adds one RAM read and answers
// once the last word is loaded. Reset leaves only the empty link; RAMs are not cleared.
// The receiver cannot stall; busy holds off new commands while a group moves or a pop reads.
module grouped_free_block_allocator
	import gfba_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic opcode,
	input wire logic [BLK_W-1:0] block_number,
	output logic done,
	output logic [1:0] status,
	output logic [BLK_W-1:0] allocated_block,
	output logic [CNT_W-1:0] group_count
);

	localparam logic [GRP_W-1:0] LAST_IDX = GRP_W'(GROUP_SIZE - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(GROUP_SIZE);
	localparam logic [BLK_W:0] MAX_BLK = (BLK_W + 1)'(NUM_BLOCKS);

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [BLK_W-1:0] link_q, link_d;
	logic [GRP_W-1:0] idx_q, idx_d;
	logic [BLK_W-1:0] blk_q, blk_d;
	logic done_q, done_d;
	status_t status_q, status_d;
	logic [BLK_W-1:0] alloc_q, alloc_d;

	logic accept;
	logic blk_ok;

	logic stk_we;
	logic [GRP_W-1:0] stk_waddr;
	logic [BLK_W-1:0] stk_wdata;
	logic [GRP_W-1:0] stk_raddr;
	logic [BLK_W-1:0] stk_rdata;

	logic spl_we;
	logic [SPILL_AW-1:0] spl_waddr;
	logic [BLK_W-1:0] spl_wdata;
	logic [SPILL_AW-1:0] spl_raddr;
	logic [BLK_W-1:0] spl_rdata;

	// Group entries above the link live in this RAM; the link is held in link_q.
	gfba_ram #(
		.ADDR_W(GRP_W),
		.DATA_W(BLK_W)
	) u_group_ram (
		.clk(clk),
		.we(stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	// Spilled groups, one row of GROUP_SIZE words per block number.
	gfba_ram #(
		.ADDR_W(SPILL_AW),
		.DATA_W(BLK_W)
	) u_spill_ram (
		.clk(clk),
		.we(spl_we),
		.waddr(spl_waddr),
		.wdata(spl_wdata),
		.raddr(spl_raddr),
		.rdata(spl_rdata)
	);

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign blk_ok = (block_number != '0) && ({1'b0, block_number} <= MAX_BLK);

	// Command decode and the group move sequencer.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		link_d = link_q;
		idx_d = idx_q;
		blk_d = blk_q;
		done_d = 1'b0;
		status_d = status_q;
		alloc_d = alloc_q;

		stk_we = 1'b0;
		stk_waddr = count_q[GRP_W-1:0];
		stk_wdata = block_number;
		stk_raddr = idx_q + GRP_W'(1);
		spl_we = 1'b0;
		spl_waddr = {blk_q, idx_q};
		spl_wdata = stk_rdata;
		spl_raddr = {blk_q, idx_q + GRP_W'(1)};

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_FREE) begin
						if (!blk_ok) begin
							done_d = 1'b1;
							status_d = ST_INVALID;
							alloc_d = '0;
						end else if (count_q != FULL_CNT) begin
							// Push onto the group.
							stk_we = 1'b1;
							count_d = count_q + CNT_W'(1);
							done_d = 1'b1;
							status_d = ST_DONE;
							alloc_d = '0;
						end else begin
							// Group is full: copy it into the freed block's row.
							spl_we = 1'b1;
							spl_waddr = {block_number, GRP_W'(0)};
							spl_wdata = link_q;
							stk_raddr = GRP_W'(1);
							idx_d = GRP_W'(1);
							blk_d = block_number;
							state_d = S_SPILL;
						end
					end else begin
						if (count_q == CNT_W'(1)) begin
							if (link_q == '0) begin
								done_d = 1'b1;
								status_d = ST_EMPTY;
								alloc_d = '0;
							end else begin
								// Only the link is left: reload its row.
								spl_raddr = {link_q, GRP_W'(0)};
								idx_d = '0;
								blk_d = link_q;
								state_d = S_REFILL;
							end
						end else begin
							// Pop the top entry.
							stk_raddr = GRP_W'(count_q - CNT_W'(1));
							count_d = count_q - CNT_W'(1);
							state_d = S_POP;
						end
					end
				end
			end
			S_POP: begin
				done_d = 1'b1;
				status_d = ST_DONE;
				alloc_d = stk_rdata;
				state_d = S_IDLE;
			end
			S_SPILL: begin
				// Read data for idx_q arrives now; the next read is issued.
				spl_we = 1'b1;
				idx_d = idx_q + GRP_W'(1);
				if (idx_q == LAST_IDX) begin
					link_d = blk_q;
					count_d = CNT_W'(1);
					done_d = 1'b1;
					status_d = ST_DONE;
					alloc_d = '0;
					state_d = S_IDLE;
				end
			end
			S_REFILL: begin
				// The first word of the row becomes the new link.
				if (idx_q == '0) begin
					link_d = spl_rdata;
				end else begin
					stk_we = 1'b1;
					stk_waddr = idx_q;
					stk_wdata = spl_rdata;
				end
				idx_d = idx_q + GRP_W'(1);
				if (idx_q == LAST_IDX) begin
					count_d = FULL_CNT;
					done_d = 1'b1;
					status_d = ST_DONE;
					alloc_d = blk_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNT_W'(1);
			link_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			link_q <= link_d;
			done_q <= done_d;
		end
	end

	// Sequencer index and result payload.
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		blk_q <= blk_d;
		status_q <= status_d;
		alloc_q <= alloc_d;
	end

	assign done = done_q;
	assign status = status_q;
	assign allocated_block = alloc_q;
	assign group_count = count_q;

`ifndef SYNTHESIS
	// A result is only shown once the group move has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// The group never holds fewer than one or more than GROUP_SIZE entries.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= FULL_CNT))
		else $error("group count out of range");

	// A push into a group with room answers in the next cycle.
	a_push_one: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_FREE) && (count_q != FULL_CNT)) |=> done)
		else $error("push did not complete in one cycle");

	// An empty pool is reported only when the link is the last, zero entry.
	a_empty_link: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == ST_EMPTY)) |-> ((count_q == CNT_W'(1)) && (link_q == '0)))
		else $error("empty status with blocks left");
`endif

endmodule

`default_nettype wire

// ===== rtl/gfba_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module gfba_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 7
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [DATA_W-1:0] wdata,
	input wire logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sim/tb_grouped_free_block_allocator.sv =====
`default_nettype none

module tb_grouped_free_block_allocator;
	import gfba_pkg::*;

	// Scoreboard for the grouped free-block allocator. It keeps its own copy of
	// the group stack and the spill rows, and it predicts one reply per command.
	class block_pool_tracker;
		typedef struct {
			status_t status;
			logic [BLK_W-1:0] block;
			logic [CNT_W-1:0] count;
		} reply_t;

		int unsigned depth;
		logic [BLK_W-1:0] group [GROUP_SIZE];
		logic [BLK_W-1:0] spill_rows [NUM_BLOCKS+1][GROUP_SIZE];
		reply_t pending_replies [$];
		int unsigned mismatches;

		function new();
			depth = 1;
			foreach (group[i])
				group[i] = '0;
			mismatches = 0;
		endfunction

		// Apply one accepted command to the shadow pool and queue its reply.
		function void note_command(logic op, logic [BLK_W-1:0] blk);
			reply_t r;
			logic [BLK_W-1:0] link;
			r.status = ST_DONE;
			r.block = '0;
			if (op == OP_FREE) begin
				if (blk == 0 || blk > NUM_BLOCKS) begin
					r.status = ST_INVALID;
				end else if (depth == GROUP_SIZE) begin
					// A full group moves into the freed block's row; that block is the new link.
					foreach (group[i])
						spill_rows[blk][i] = group[i];
					foreach (group[i])
						group[i] = '0;
					group[0] = blk;
					depth = 1;
				end else begin
					group[depth] = blk;
					depth++;
				end
			end else if (depth == 1) begin
				link = group[0];
				if (link == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// Only the link is left: reload its row and hand out the link block.
					foreach (group[i])
						group[i] = spill_rows[link][i];
					depth = GROUP_SIZE;
					r.block = link;
				end
			end else begin
				r.block = group[depth-1];
				depth--;
			end
			r.count = depth[CNT_W-1:0];
			pending_replies = {pending_replies, r};
		endfunction

		// Compare one reply from the block with the oldest prediction.
		function void check_reply(logic [1:0] st, logic [BLK_W-1:0] blk,
				logic [CNT_W-1:0] cnt);
			reply_t e;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected reply: status %0d block %0d count %0d",
						st, blk, cnt);
				return;
			end
			e = pending_replies.pop_front();
			if (st !== e.status || blk !== e.block || cnt !== e.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"Reply mismatch: expected status %0d block %0d count %0d, ",
						"got status %0d block %0d count %0d"},
						e.status, e.block, e.count, st, blk, cnt);
			end
		endfunction

		function int unsigned outstanding();
			return pending_replies.size();
		endfunction
	endclass

	localparam int RANDOM_COMMANDS = 800;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic opcode;
	logic [BLK_W-1:0] block_number;
	logic done;
	logic [1:0] status;
	logic [BLK_W-1:0] allocated_block;
	logic [CNT_W-1:0] group_count;

	block_pool_tracker pool;

	grouped_free_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.block_number(block_number),
		.done(done),
		.status(status),
		.allocated_block(allocated_block),
		.group_count(group_count)
	);

	// Clock with a period of two time units.
	always #1 clk = ~clk;

	// Every reply strobe is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			pool.check_reply(status, allocated_block, group_count);
	end

	// Present one command and hold it until the block takes the transfer.
	task automatic send_command(input logic op, input logic [BLK_W-1:0] blk);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		block_number <= blk;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pool.note_command(op, blk);
	endtask

	// Keep start low for a number of cycles.
	task automatic hold_off(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Mostly short gaps, now and then a long one.
	task automatic random_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			hold_off(0);
		else if (r < 95)
			hold_off($urandom_range(1, 3));
		else
			hold_off($urandom_range(8, 40));
	endtask

	// Wait with start low until every predicted reply has arrived.
	task automatic drain_replies();
		hold_off(1);
		while (pool.outstanding() > 0)
			@(posedge clk);
	endtask

	task automatic return_block(input logic [BLK_W-1:0] blk);
		send_command(OP_FREE, blk);
	endtask

	task automatic alloc_block();
		send_command(OP_ALLOC, BLK_W'($urandom));
	endtask

	// Fixed time limit for the whole run.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned issued;
		int unsigned mode;
		int unsigned burst;
		int unsigned free_pct;
		int unsigned guard;
		bit no_gaps;
		logic [BLK_W-1:0] blk;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_ALLOC;
		block_number = '0;
		pool = new();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		hold_off(2);

		// Directed commands: empty pool, rejected block zero, the largest and
		// smallest block numbers, double free, and draining back to empty.
		alloc_block();
		return_block(BLK_W'(0));
		return_block(BLK_W'(NUM_BLOCKS));
		return_block(BLK_W'(1));
		alloc_block();
		alloc_block();
		alloc_block();
		return_block(BLK_W'(85));
		hold_off(5);
		return_block(BLK_W'(42));
		return_block(BLK_W'(5));
		return_block(BLK_W'(5));
		alloc_block();
		alloc_block();
		alloc_block();
		alloc_block();
		alloc_block();
		return_block(BLK_W'(0));
		drain_replies();

		// Random bursts: filling bursts spill groups, draining bursts refill
		// them and run the pool dry, mixed bursts wander in between.
		issued = 0;
		while (issued < RANDOM_COMMANDS) begin
			mode = $urandom_range(0, 2);
			burst = $urandom_range(5, 60);
			no_gaps = ($urandom_range(0, 3) == 0);
			free_pct = (mode == 0) ? 90 : (mode == 1) ? 10 : 50;
			repeat (burst) begin
				if ($urandom_range(0, 99) < free_pct) begin
					if ($urandom_range(0, 99) < 4)
						blk = '0;
					else
						blk = BLK_W'($urandom_range(1, NUM_BLOCKS));
					return_block(blk);
				end else begin
					alloc_block();
				end
				issued++;
				if (!no_gaps)
					random_gap();
			end
			if ($urandom_range(0, 5) == 0)
				drain_replies();
		end

		// Let the last replies come in, then allow for a full group move.
		hold_off(1);
		guard = 0;
		while (pool.outstanding() > 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (GROUP_SIZE + 4) @(posedge clk);

		if (pool.mismatches == 0 && pool.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
